[design/slim_pkg.sv]
package slim_pkg;

  localparam int MaxSegments = 16;
  localparam int XW = 15;
  localparam int YW = 16;
  localparam int SW = 16;
  localparam int CW = 20;
  localparam logic [CW-1:0] CountMax = 20'hFFFFF;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_I2P = 3'd2;
  localparam logic [2:0] OP_P2I = 3'd3;
  localparam logic [2:0] OP_CLR = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_TWOD  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [SW:0]   w;
    logic [SW:0]   h;
  } seg_t;

  function automatic logic [SW:0] seg_len(input seg_t s);
    return (s.w > 17'd1) ? s.w : s.h;
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [SW:0] b);
    logic [CW:0] t;
    t = {1'b0, a} + {{(CW-SW-1){1'b0}}, 1'b0, b};
    return t[CW] ? CountMax : t[CW-1:0];
  endfunction

endpackage

[design/segment_list_index_mapper.sv]
// Segment list index mapper: one result beat per input beat, one beat in flight.
// Sequence from input accept to result valid: add, clear and unknown ops run the
// summary walk; lookups run a search walk, then a summary walk; subtract runs an
// orientation pass, a trim pass with compaction, then a summary walk.
// The next input beat is taken in the cycle after the result beat is accepted.
// Synchronous reset empties the table; memory contents stay undefined.
module segment_list_index_mapper #(
  parameter int MAX_SEGMENTS = slim_pkg::MaxSegments
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [14:0] x,
  input  logic [15:0] y,
  input  logic [15:0] seg_width,
  input  logic [15:0] seg_height,
  input  logic [19:0] index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [14:0] out_x,
  output logic [15:0] out_y,
  output logic [19:0] out_index,
  output logic        horizontal,
  output logic [19:0] cell_count,
  output logic [4:0]  segment_count,
  output logic [14:0] bound_left,
  output logic [15:0] bound_top,
  output logic [14:0] bound_right,
  output logic [15:0] bound_bottom
);
  import slim_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int NW = $clog2(MAX_SEGMENTS + 1);

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;  // query / subtract search walk
  localparam logic [2:0] S_SUM  = 3'd2;  // summary walk (orientation, count, box)
  localparam logic [2:0] S_SHFT = 3'd3;  // move entries up after a removal
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state;
  logic [2:0]    cop;
  logic [XW-1:0] qx;
  logic [YW-1:0] qy;
  logic [CW-1:0] qidx;
  logic [NW-1:0] used;
  logic [NW-1:0] ptr;       // entry presented on the memory read this cycle
  logic          rd_live;   // rdata holds entry ptr-1
  logic [AW-1:0] rd_at;
  logic          found;
  logic [2:0]    st;

  // summary accumulators
  logic          hz_known, hz, hz_seen;
  logic [CW-1:0] sum_w, sum_h, acc;
  logic          bx_v;
  logic [XW-1:0] bl, br;
  logic [YW-1:0] bt, bb;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  seg_t          wdata, rdata;

  slim_seg_mem #(.Depth(MAX_SEGMENTS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  // segment geometry of the entry on rdata
  logic [XW:0] r_end;
  logic [YW:0] b_end;
  logic        holds;
  logic [SW:0] rlen;
  logic [CW:0] acc_len;
  assign r_end   = {1'b0, rdata.x} + rdata.w[XW:0] - 1'b1;
  assign b_end   = {1'b0, rdata.y} + rdata.h[YW:0] - 1'b1;
  assign holds   = (qx >= rdata.x) && ({1'b0, qx} <= r_end)
                && (qy >= rdata.y) && ({1'b0, qy} <= b_end);
  assign rlen    = seg_len(rdata);
  assign acc_len = {1'b0, acc} + {{(CW-SW){1'b0}}, rlen};

  // add clipping
  logic [SW:0] cw, ch, xroom, yroom;
  assign xroom = 17'd32768 - {2'b0, x};
  assign yroom = 17'd65536 - {1'b0, y};
  assign cw = ({1'b0, seg_width}  > xroom) ? xroom : {1'b0, seg_width};
  assign ch = ({1'b0, seg_height} > yroom) ? yroom : {1'b0, seg_height};

  // trimmed entry for subtract
  seg_t trim;
  always_comb begin
    trim = rdata;
    if (hz) begin
      if (rdata.x == qx) begin
        trim.x = rdata.x + 1'b1;
        trim.w = rdata.w - 1'b1;
      end else if (r_end[XW-1:0] == qx && !r_end[XW]) begin
        trim.w = rdata.w - 1'b1;
      end
    end else begin
      if (rdata.y == qy) begin
        trim.y = rdata.y + 1'b1;
        trim.h = rdata.h - 1'b1;
      end else if (b_end[YW-1:0] == qy && !b_end[YW]) begin
        trim.h = rdata.h - 1'b1;
      end
    end
  end

  always_comb begin
    raddr = ptr[AW-1:0];
    we = 1'b0;
    waddr = rd_at;
    wdata = trim;
    if (state == S_IDLE && in_valid && in_ready && op == OP_ADD) begin
      we = (seg_width != '0) && (seg_height != '0)
        && !(seg_width > 16'd1 && seg_height > 16'd1) && (used < NW'(MAX_SEGMENTS));
      waddr = used[AW-1:0];
      wdata = '{x: x, y: y, w: cw, h: ch};
    end else if (state == S_LOOK && rd_live && cop == OP_SUB && hz_known && holds
                 && !found) begin
      we = (trim.w != '0) && (trim.h != '0);
    end else if (state == S_SHFT && rd_live) begin
      we = 1'b1;
      waddr = rd_at - 1'b1;
      wdata = rdata;
    end
  end

  // orientation of the first entry that decides it, used by subtract
  logic hz_next;
  assign hz_next = hz_known ? hz : (rdata.w > 17'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      used <= '0;
      ptr <= '0;
      rd_live <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cop <= op; qx <= x; qy <= y; qidx <= index;
            found <= 1'b0; acc <= '0;
            out_x <= '0; out_y <= '0; out_index <= '0;
            hz_known <= 1'b0; hz <= 1'b0;
            ptr <= '0; rd_live <= 1'b0;
            if (op == OP_SUB || op == OP_I2P || op == OP_P2I) begin
              st <= ST_NONE;
              state <= S_LOOK;
            end else begin
              state <= S_SUM;
              if (op == OP_ADD && (seg_width == '0 || seg_height == '0)) st <= ST_EMPTY;
              else if (op == OP_ADD && seg_width > 16'd1 && seg_height > 16'd1) st <= ST_TWOD;
              else if (op == OP_ADD && used >= NW'(MAX_SEGMENTS)) st <= ST_FULL;
              else begin
                st <= ST_OK;
                if (op == OP_ADD) used <= used + 1'b1;
                else if (op == OP_CLR) used <= '0;
              end
            end
          end
        end
        S_LOOK: begin
          // walk: issue read ptr, examine entry ptr-1
          if (rd_live && !found) begin
            if (cop == OP_I2P) begin
              if (acc_len > {1'b0, qidx}) begin
                found <= 1'b1; st <= ST_OK;
                if (rdata.w > 17'd1) begin
                  out_x <= rdata.x + XW'(qidx - acc);
                  out_y <= rdata.y;
                end else begin
                  out_x <= rdata.x;
                  out_y <= rdata.y + YW'(qidx - acc);
                end
              end else begin
                acc <= acc_len[CW] ? CountMax : acc_len[CW-1:0];
              end
            end else if (cop == OP_P2I) begin
              if (holds) begin
                found <= 1'b1; st <= ST_OK;
                out_index <= sat_add(acc, (rdata.w > 17'd1) ? 17'(qx - rdata.x)
                                                            : 17'(qy - rdata.y));
              end else begin
                acc <= acc_len[CW] ? CountMax : acc_len[CW-1:0];
              end
            end else begin
              // subtract: orientation is settled by a pre-pass (hz_known)
              if (!hz_known) begin
                if (rdata.w > 17'd1 || rdata.h > 17'd1) hz_known <= 1'b1;
                hz <= hz_next;
              end else if (holds) begin
                found <= 1'b1; st <= ST_OK;
                if (trim.w == '0 || trim.h == '0) begin
                  used <= used - 1'b1;
                  state <= S_SHFT;
                end
              end
            end
          end
          if (state == S_LOOK) begin
            if (cop == OP_SUB && !hz_known && rd_live
                && (rdata.w > 17'd1 || rdata.h > 17'd1)) begin
              ptr <= '0; rd_live <= 1'b0;         // restart for the trim pass
            end else if ((rd_live && !found && ptr == used)
                      || (found && rd_live) || (used == '0)) begin
              if (cop == OP_SUB && !hz_known && !found && used != '0) begin
                hz_known <= 1'b1; ptr <= '0; rd_live <= 1'b0;
              end else if (!(cop == OP_SUB && holds && hz_known
                             && (trim.w == '0 || trim.h == '0) && !found)) begin
                state <= S_SUM; ptr <= '0; rd_live <= 1'b0;
              end else begin
                ptr <= ptr + 1'b1; rd_live <= 1'b1; rd_at <= ptr[AW-1:0];
              end
            end else if (!found) begin
              rd_live <= (ptr != used);
              rd_at <= ptr[AW-1:0];
              if (ptr != used) ptr <= ptr + 1'b1;
            end
          end
        end
        S_SHFT: begin
          // move entries at and after ptr up one place
          if (ptr > used) begin
            state <= S_SUM; ptr <= '0; rd_live <= 1'b0;
          end else begin
            rd_live <= 1'b1;
            rd_at <= ptr[AW-1:0];
            ptr <= ptr + 1'b1;
          end
        end
        S_SUM: begin
          if (!rd_live && ptr == '0) begin
            hz_seen <= 1'b0; hz <= 1'b0;
            sum_w <= '0; sum_h <= '0; bx_v <= 1'b0;
            bl <= '0; bt <= '0; br <= '0; bb <= '0;
          end
          if (rd_live) begin
            if (!hz_seen) begin
              if (rdata.w > 17'd1) begin hz_seen <= 1'b1; hz <= 1'b1; end
              else if (rdata.h > 17'd1) begin hz_seen <= 1'b1; hz <= 1'b0; end
            end
            sum_w <= sat_add(sum_w, rdata.w);
            sum_h <= sat_add(sum_h, rdata.h);
            bx_v <= 1'b1;
            if (!bx_v || rdata.x < bl) bl <= rdata.x;
            if (!bx_v || rdata.y < bt) bt <= rdata.y;
            if (!bx_v || r_end[XW-1:0] > br) br <= r_end[XW-1:0];
            if (!bx_v || b_end[YW-1:0] > bb) bb <= b_end[YW-1:0];
          end
          if (ptr == used && (rd_live || used == '0 || ptr == '0 && rd_live)) begin
            state <= S_DONE; rd_live <= 1'b0;
          end else if (ptr == used) begin
            state <= S_DONE; rd_live <= 1'b0;
          end else begin
            rd_live <= 1'b1; rd_at <= ptr[AW-1:0]; ptr <= ptr + 1'b1;
          end
        end
        S_DONE: begin
          status <= st;
          horizontal <= hz;
          cell_count <= hz ? sum_w : sum_h;
          segment_count <= 5'(used);
          bound_left <= bl; bound_top <= bt; bound_right <= br; bound_bottom <= bb;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[design/slim_seg_mem.sv]
module slim_seg_mem #(
  parameter int Depth = slim_pkg::MaxSegments,
  parameter int AW = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  slim_pkg::seg_t  wdata,
  input  logic [AW-1:0]   raddr,
  output slim_pkg::seg_t  rdata
);
  import slim_pkg::*;

  seg_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
